@@ sv/tmwf_pkg.sv @@
// Shared constants and types for the trimmed-mean window filter.
package tmwf_pkg;

  localparam int unsigned WINDOW_LEN = 8;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned IDX_W      = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W      = SAMPLE_W + IDX_W + 1;
  localparam int unsigned DCNT_W     = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

@@ sv/trimmed_mean_window_filter_top.sv @@
// Trimmed-mean sliding window filter: window memory, scan, divider and output register.
// An accepted word is handled in turn by the memory scan over the n stored samples
// (WINDOW_LEN once full), one entry per cycle, a prep step and the restoring divider,
// one quotient bit per cycle; the result then waits for the output register. The block
// takes a new word only when idle, so in_ready stays low until the result is registered.
// Reset clears the write position, the full flag, the controller and the output valid flag;
// the window memory is not cleared and is only read at entries already written.
module trimmed_mean_window_filter_top
  import tmwf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] filtered_o,
  output logic                       trimmed_o
);

  // Window memory: one write port, one registered read port.
  logic signed [SAMPLE_W-1:0] mem [WINDOW_LEN];
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;

  // Control state.
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  wpos_q, wpos_d;
  logic              full_q, full_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              trim_q, trim_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              out_valid_q, out_valid_d;

  // Datapath state.
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [SUM_W-1:0]           quo_q, quo_d;
  logic [CNT_W-1:0]           rem_q, rem_d;
  logic [CNT_W-1:0]           div_q, div_d;
  logic                       neg_q, neg_d;
  logic signed [SAMPLE_W-1:0] filt_q, filt_d;
  logic                       trimmed_q, trimmed_d;

  // Helper values.
  logic                       in_fire;
  logic                       wrap;
  logic signed [SUM_W-1:0]    rd_ext, lo_ext, hi_ext, dividend;
  logic [CNT_W:0]             rem_sh;
  logic [SUM_W-1:0]           quo_signed;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign wrap        = (wpos_q == IDX_W'(WINDOW_LEN - 1));
  assign wr_en       = in_fire;
  assign rd_en       = (state_q == ST_SCAN) && (idx_q != n_q);
  assign rd_addr     = idx_q[IDX_W-1:0];
  assign out_valid_o = out_valid_q;
  assign filtered_o  = filt_q;
  assign trimmed_o   = trimmed_q;

  assign rd_ext   = {{(SUM_W-SAMPLE_W){rd_data_q[SAMPLE_W-1]}}, rd_data_q};
  assign lo_ext   = {{(SUM_W-SAMPLE_W){lo_q[SAMPLE_W-1]}}, lo_q};
  assign hi_ext   = {{(SUM_W-SAMPLE_W){hi_q[SAMPLE_W-1]}}, hi_q};
  assign dividend = trim_q ? (sum_q - lo_ext - hi_ext) : sum_q;

  // One restoring division step: the remainder always stays below the divisor.
  assign rem_sh     = {rem_q, quo_q[SUM_W-1]};
  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wpos_q] <= sample_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    full_d      = full_q;
    idx_d       = idx_q;
    n_d         = n_q;
    trim_d      = trim_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sum_d       = sum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    neg_d       = neg_q;
    filt_d      = filt_q;
    trimmed_d   = trimmed_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // The sample lands in memory at this edge; the scan starts next cycle.
          wpos_d  = wrap ? '0 : (wpos_q + IDX_W'(1));
          full_d  = full_q || wrap;
          trim_d  = full_q || wrap;
          n_d     = (full_q || wrap) ? CNT_W'(WINDOW_LEN) : (CNT_W'(wpos_q) + CNT_W'(1));
          idx_d   = '0;
          sum_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Data read in the previous cycle belongs to entry idx_q - 1.
        if (idx_q != '0) begin
          sum_d = sum_q + rd_ext;
          if (idx_q == CNT_W'(1)) begin
            lo_d = rd_data_q;
            hi_d = rd_data_q;
          end else begin
            if (rd_data_q < lo_q) lo_d = rd_data_q;
            if (rd_data_q > hi_q) hi_d = rd_data_q;
          end
        end
        if (idx_q == n_q) begin
          state_d = ST_PREP;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_PREP: begin
        // Divide magnitudes and restore the sign afterwards: truncation toward zero.
        neg_d   = dividend[SUM_W-1];
        quo_d   = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
        rem_d   = '0;
        div_d   = trim_q ? CNT_W'(WINDOW_LEN - 2) : n_q;
        dcnt_d  = DCNT_W'(SUM_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = CNT_W'(rem_sh - {1'b0, div_q});
          quo_d = {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[CNT_W-1:0];
          quo_d = {quo_q[SUM_W-2:0], 1'b0};
        end
        if (dcnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          dcnt_d = dcnt_q - DCNT_W'(1);
        end
      end
      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          filt_d      = quo_signed[SAMPLE_W-1:0];
          trimmed_d   = trim_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wpos_q      <= '0;
      full_q      <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      trim_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      full_q      <= full_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      trim_q      <= trim_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    neg_q     <= neg_d;
    filt_q    <= filt_d;
    trimmed_q <= trimmed_d;
  end

`ifndef NO_ASSERTIONS
  // Once the window has filled it stays full.
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("window full flag dropped");

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_q != '0))
    else $error("divider started with zero divisor");

  // A partial window scans exactly the entries written so far.
  a_partial_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && !trim_q) |-> (n_q == CNT_W'(wpos_q)))
    else $error("partial window count does not match write position");

  // A finished result waits while the previous word is still unclaimed.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result overwrote a pending output word");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the trimmed-mean window filter: directed and random words.
module tb
  import tmwf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Generous cycle budget: roughly 800 words, each held up by the scan and the divider and
  // stretched by random sender gaps and receiver stalls, and then taken many times over.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_WORDS  = 750;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       trimmed;
  } mean_word_t;

  // The scoreboard keeps its own copy of the sample ring and predicts the mean that
  // each accepted sample produces. Expected words are checked strictly in order.
  class mean_checker;
    logic signed [SAMPLE_W-1:0] ring [WINDOW_LEN];
    int unsigned                ring_pos;
    bit                         ring_full;
    mean_word_t                 expected_means [$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                trimmed_seen;

    function new();
      ring_pos  = 0;
      ring_full = 1'b0;
      errors    = 0;
      checked   = 0;
      trimmed_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction

    // Store the sample, advance the ring, and queue the mean that must come out.
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      longint     total;
      longint     lo;
      longint     hi;
      longint     v;
      mean_word_t w;
      total = 0;
      ring[ring_pos] = s;
      ring_pos++;
      if (ring_pos == WINDOW_LEN) begin
        ring_pos  = 0;
        ring_full = 1'b1;
      end
      if (ring_full) begin
        // Full window: drop one smallest and one largest sample.
        lo = longint'(ring[0]);
        hi = longint'(ring[0]);
        for (int i = 0; i < WINDOW_LEN; i++) begin
          v = longint'(ring[i]);
          total += v;
          if (v < lo) lo = v;
          if (v > hi) hi = v;
        end
        total     = total - lo - hi;
        w.filtered = SAMPLE_W'(total / longint'(WINDOW_LEN - 2));
        w.trimmed  = 1'b1;
      end else begin
        // Partial window: plain mean of what has arrived, never a zero divisor here.
        for (int i = 0; i < ring_pos; i++) total += longint'(ring[i]);
        w.filtered = SAMPLE_W'(total / longint'(ring_pos));
        w.trimmed  = 1'b0;
      end
      expected_means.push_back(w);
    endfunction

    function void check_mean(logic signed [SAMPLE_W-1:0] filtered, logic trimmed);
      mean_word_t w;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result word filtered=%0d trimmed=%0b",
                 $time, filtered, trimmed);
        errors++;
        return;
      end
      w = expected_means.pop_front();
      checked++;
      if (trimmed) trimmed_seen++;
      if (filtered !== w.filtered) begin
        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                 $time, w.filtered, filtered);
        errors++;
      end
      if (trimmed !== w.trimmed) begin
        $display("%0t: trimmed mismatch, expected %0b, actual %0b",
                 $time, w.trimmed, trimmed);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       trimmed;

  // Random idling on each side is switched off for one long stretch of the run.
  bit          send_gaps_on = 1'b1;
  bit          recv_stalls_on = 1'b1;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  mean_checker book = new();

  always #1 clk = ~clk;

  trimmed_mean_window_filter_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .filtered_o  (filtered),
    .trimmed_o   (trimmed)
  );

  // Result side: the handshake is judged on the values that held before the edge,
  // then ready is redrawn for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.check_mean(filtered, trimmed);
    end
    out_ready <= recv_stalls_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, book.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it. Valid drops only during
  // an idle gap, so it is never lowered and raised within the same step.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (send_gaps_on) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    book.note_sample(s);
    words_sent++;
  endtask

  // Hold the sender back until every queued mean has come out of the block.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Random samples: mostly full range, with small values, rail values and tight
  // clusters mixed in so that ties and near-ties for min and max show up.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      5, 6: random_sample = SAMPLE_W'(int'($urandom_range(200)) - 100);
      7: random_sample = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      8: random_sample = $urandom_range(1) ? SAMPLE_MAX - SAMPLE_W'($urandom_range(3))
                                           : SAMPLE_MIN + SAMPLE_W'($urandom_range(3));
      default: random_sample = SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] directed [$];

    // The first seven words see a partial window and must give a plain mean. They include
    // both rails and negative sums, so truncation toward zero is exercised.
    directed = '{SAMPLE_MAX, SAMPLE_MIN, -24'sd3, 24'sd5, 24'h555555, 24'hAAAAAA, -24'sd1,
                 // The eighth word fills the window: the first trimmed mean.
                 24'sd0};
    // A window of all maximum, then all minimum, values: ties for both extremes.
    repeat (8) directed.push_back(SAMPLE_MAX);
    repeat (8) directed.push_back(SAMPLE_MIN);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i]);
    wait_for_drain();

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // A long stretch with no idling on either side.
      send_gaps_on   = !(n >= 300 && n < 450);
      recv_stalls_on = !(n >= 300 && n < 450);
      if (n % 200 == 199) wait_for_drain();
      send_sample(random_sample());
    end

    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples through a %0d-entry window; checked %0d means",
             words_sent, WINDOW_LEN, book.checked);
    $display("(%0d trimmed, %0d from a partial window), %0d errors.",
             book.trimmed_seen, book.checked - book.trimmed_seen, book.errors);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
